>>> hdl/refcounted_block_allocator_unit_defines.svh
// assertion macros used by the allocator top module
`ifndef REFCOUNTED_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define REFCOUNTED_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// clocked check, skipped while reset is held
`define RBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also runs during reset
`define RBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/rba_pkg.sv
// types and constants of the refcounted block allocator
package rba_pkg;

  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned IdW       = 10;
  localparam int unsigned CountW    = 16;
  localparam int unsigned DepthW    = 11;

  localparam logic [CountW-1:0] CountMax    = '1;
  localparam logic [DepthW-1:0] ActiveReset = DepthW'(MaxBlocks);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_INC   = 2'd1,
    OP_DEC   = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BAD_ID   = 3'd2,
    ST_FREE     = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef struct packed {
    op_e            op;
    logic [IdW-1:0] block_id;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0]    result_id;
    status_e           status;
    logic [CountW-1:0] ref_count;
    logic [DepthW-1:0] free_count;
  } rsp_t;

  // clearing pass: busy while it writes entry addr
  typedef struct packed {
    logic           busy;
    logic [IdW-1:0] addr;
  } init_t;

  typedef struct packed {
    logic           pop;
    logic           push;
    logic [IdW-1:0] push_id;
  } stack_cmd_t;

endpackage

>>> hdl/rba_init_seq.sv
// clearing pass sequencer for both memories after reset or a pool resize
module rba_init_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output rba_pkg::init_t init_o
);
  import rba_pkg::*;

  logic           busy_q, busy_d;
  logic [IdW-1:0] ptr_q, ptr_d;

  always_comb begin
    busy_d = busy_q;
    ptr_d  = ptr_q;
    if (start_i) begin
      busy_d = 1'b1;
      ptr_d  = '0;
    end else if (busy_q) begin
      ptr_d = ptr_q + IdW'(1);
      if (ptr_q == IdW'(MaxBlocks - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      ptr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      ptr_q  <= ptr_d;
    end
  end

  assign init_o.busy = busy_q;
  assign init_o.addr = ptr_q;

endmodule

>>> hdl/rba_free_stack.sv
// free id stack: one memory plus the depth register
module rba_free_stack (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rba_pkg::init_t              init_i,
  input  logic                        load_i,
  input  logic [rba_pkg::DepthW-1:0]  load_depth_i,
  input  logic                        rd_en_i,
  input  rba_pkg::stack_cmd_t         cmd_i,
  output logic [rba_pkg::IdW-1:0]     top_o,
  output logic [rba_pkg::DepthW-1:0]  depth_o
);
  import rba_pkg::*;

  logic [IdW-1:0]    mem [MaxBlocks];
  logic [IdW-1:0]    top_q;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [DepthW-1:0] depth_m1;
  logic [IdW-1:0]    rd_addr;
  logic [IdW-1:0]    wr_addr;

  assign depth_m1 = depth_q - DepthW'(1);
  assign rd_addr  = depth_m1[IdW-1:0];
  // a push only happens below full depth, so the low bits address the slot
  assign wr_addr  = depth_q[IdW-1:0];

  always_ff @(posedge clk_i) begin
    if (init_i.busy) begin
      mem[init_i.addr] <= init_i.addr;
    end else if (cmd_i.push) begin
      mem[wr_addr] <= cmd_i.push_id;
    end
    if (rd_en_i) begin
      top_q <= mem[rd_addr];
    end
  end

  always_comb begin
    depth_d = depth_q;
    if (load_i) begin
      depth_d = load_depth_i;
    end else if (cmd_i.pop) begin
      depth_d = depth_m1;
    end else if (cmd_i.push) begin
      depth_d = depth_q + DepthW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= ActiveReset;
    end else begin
      depth_q <= depth_d;
    end
  end

  assign top_o   = top_q;
  assign depth_o = depth_q;

endmodule

>>> hdl/rba_count_table.sv
// reference count memory, one write and one registered read port
module rba_count_table (
  input  logic                        clk_i,
  input  rba_pkg::init_t              init_i,
  input  logic                        rd_en_i,
  input  logic [rba_pkg::IdW-1:0]     rd_addr_i,
  input  logic                        wr_en_i,
  input  logic [rba_pkg::IdW-1:0]     wr_addr_i,
  input  logic [rba_pkg::CountW-1:0]  wr_data_i,
  output logic [rba_pkg::CountW-1:0]  rd_data_o
);
  import rba_pkg::*;

  logic [CountW-1:0] mem [MaxBlocks];
  logic [CountW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (init_i.busy) begin
      mem[init_i.addr] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/refcounted_block_allocator_unit.sv
// Refcounted block allocator: pool of block ids with a count per block and a free id stack.
// Request channel: in_valid_i/in_ready_o carry a word {op, block_id}; allocate,
// increment, decrement or query. Response channel: out_valid_o/out_ready_i carry
// one word {result_id, status, ref_count, free_count} for every request.
// A request is registered on accept together with its count memory read; its response
// word is registered once the output register is free. A new request is taken only after
// the held one completes: the count memory is read at accept and written back at completion.
// Only one request is in flight, so no two accesses to one entry overlap.
// A finished response sits in the output register; a new request is taken meanwhile,
// and its write-back waits until that response is taken.
// Reset and every write of cfg_we_i/cfg_wdata_i run a clearing pass over all 1024 entries
// that refills the free stack with ids in ascending order and zeroes all counts;
// in_ready_o stays low during the pass. The pool size written is clamped to 1024.
// Configuration writes are taken in any cycle and expect the block to be idle.
`include "refcounted_block_allocator_unit_defines.svh"

module refcounted_block_allocator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rba_pkg::DepthW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rba_pkg::req_t              in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rba_pkg::rsp_t              out_rsp_o
);
  import rba_pkg::*;

  init_t             init;
  stack_cmd_t        stack_cmd;
  logic [IdW-1:0]    top;
  logic [DepthW-1:0] depth;
  logic [DepthW-1:0] cfg_clamped;
  logic [CountW-1:0] cnt_rd;

  logic [DepthW-1:0] active_q, active_d;
  logic              busy_q, busy_d;
  req_t              req_q;
  logic              out_valid_q, out_valid_d;
  rsp_t              rsp_q, rsp_d;

  logic              in_fire;
  logic              fire;
  logic              pop, push;
  logic              cnt_we;
  logic [IdW-1:0]    cnt_waddr;
  logic [CountW-1:0] cnt_wdata;

  assign in_ready_o = ~busy_q & ~init.busy;
  assign in_fire    = in_valid_i & in_ready_o;
  // the held request completes once the output register can take its word
  assign fire       = busy_q & (~out_valid_q | out_ready_i);

  assign cfg_clamped = (cfg_wdata_i > ActiveReset) ? ActiveReset : cfg_wdata_i;

  rba_init_seq u_init (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we_i),
    .init_o  (init)
  );

  assign stack_cmd.pop     = fire & pop;
  assign stack_cmd.push    = fire & push;
  assign stack_cmd.push_id = req_q.block_id;

  rba_free_stack u_stack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .init_i       (init),
    .load_i       (cfg_we_i),
    .load_depth_i (cfg_clamped),
    .rd_en_i      (in_fire),
    .cmd_i        (stack_cmd),
    .top_o        (top),
    .depth_o      (depth)
  );

  rba_count_table u_counts (
    .clk_i     (clk_i),
    .init_i    (init),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_req_i.block_id),
    .wr_en_i   (fire & cnt_we),
    .wr_addr_i (cnt_waddr),
    .wr_data_i (cnt_wdata),
    .rd_data_o (cnt_rd)
  );

  always_comb begin
    rsp_d           = '0;
    rsp_d.result_id = req_q.block_id;
    rsp_d.status    = ST_OK;
    pop             = 1'b0;
    push            = 1'b0;
    cnt_we          = 1'b0;
    cnt_waddr       = req_q.block_id;
    cnt_wdata       = '0;
    case (req_q.op)
      OP_ALLOC: begin
        if (depth == '0) begin
          rsp_d.status    = ST_EMPTY;
          rsp_d.result_id = '0;
        end else begin
          pop             = 1'b1;
          rsp_d.result_id = top;
          rsp_d.ref_count = CountW'(1);
          cnt_we          = 1'b1;
          cnt_waddr       = top;
          cnt_wdata       = CountW'(1);
        end
      end
      default: begin
        if ({1'b0, req_q.block_id} >= active_q) begin
          rsp_d.status = ST_BAD_ID;
        end else begin
          case (req_q.op)
            OP_QUERY: begin
              rsp_d.ref_count = cnt_rd;
            end
            OP_INC: begin
              if (cnt_rd == '0) begin
                rsp_d.status = ST_FREE;
              end else if (cnt_rd == CountMax) begin
                rsp_d.status    = ST_OVERFLOW;
                rsp_d.ref_count = cnt_rd;
              end else begin
                cnt_we          = 1'b1;
                cnt_wdata       = cnt_rd + CountW'(1);
                rsp_d.ref_count = cnt_wdata;
              end
            end
            OP_DEC: begin
              if (cnt_rd == '0) begin
                rsp_d.status = ST_FREE;
              end else begin
                cnt_we          = 1'b1;
                cnt_wdata       = cnt_rd - CountW'(1);
                rsp_d.ref_count = cnt_wdata;
                // last reference gone: the id goes back on the stack
                push = (cnt_rd == CountW'(1)) && (depth < ActiveReset);
              end
            end
            default: begin
              rsp_d.status = ST_OK;
            end
          endcase
        end
      end
    endcase
    if (pop) begin
      rsp_d.free_count = depth - DepthW'(1);
    end else if (push) begin
      rsp_d.free_count = depth + DepthW'(1);
    end else begin
      rsp_d.free_count = depth;
    end
  end

  always_comb begin
    active_d = cfg_we_i ? cfg_clamped : active_q;
    busy_d   = busy_q;
    if (in_fire) begin
      busy_d = 1'b1;
    end else if (fire) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= ActiveReset;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_req_i;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  `RBA_ASSERT(depth_le_active, depth <= active_q, "free stack deeper than the pool")
  `RBA_ASSERT(done_gives_word, fire |=> out_valid_o, "finished request gave no response word")
  `RBA_ASSERT(no_wb_in_clear, (fire && cnt_we) |-> !init.busy, "write-back during clear")
  `RBA_ASSERT(popped_id_in_pool, (fire && pop) |-> ({1'b0, top} < active_q), "id outside pool")
  `RBA_ASSERT_ALWAYS(no_accept_in_reset, !rst_ni |-> !in_ready_o, "request taken during reset")

endmodule

>>> test/tb_refcounted_block_allocator_unit.sv
// testbench for the refcounted block allocator: random and directed requests
module tb_refcounted_block_allocator_unit;
  import rba_pkg::*;

  localparam int unsigned WatchdogLimit = 6000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b1;
  logic               cfg_we_i    = 1'b0;
  logic [DepthW-1:0]  cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  req_t               in_req_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  rsp_t               out_rsp_o;

  refcounted_block_allocator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // predicted allocator state
  logic [DepthW-1:0] pool_size;
  logic [DepthW-1:0] free_depth;
  logic [IdW-1:0]    free_ids   [MaxBlocks];
  logic [CountW-1:0] ref_counts [MaxBlocks];

  req_t        req_backlog[$];
  rsp_t        rsp_due[$];
  int          mismatches   = 0;
  bit          idle_on      = 1'b1;
  int unsigned in_gap       = 0;
  int unsigned in_calm      = 0;
  int unsigned out_hold     = 0;
  int unsigned out_calm     = 0;
  int unsigned quiet_cycles = 0;

  function automatic void pool_setup(input logic [DepthW-1:0] blocks);
    logic [DepthW-1:0] clamped;
    clamped = (blocks > DepthW'(MaxBlocks)) ? DepthW'(MaxBlocks) : blocks;
    for (int unsigned i = 0; i < MaxBlocks; i++) begin
      free_ids[i]   = IdW'(i);
      ref_counts[i] = '0;
    end
    pool_size  = clamped;
    free_depth = clamped;
  endfunction

  function automatic rsp_t predict_rsp(input req_t req);
    rsp_t           r;
    logic [IdW-1:0] id;
    id          = req.block_id;
    r.result_id = id;
    r.status    = ST_OK;
    r.ref_count = '0;
    if (req.op == OP_ALLOC) begin
      if (free_depth == 0) begin
        r.status    = ST_EMPTY;
        r.result_id = '0;
      end else begin
        free_depth             = free_depth - 1'b1;
        r.result_id            = free_ids[free_depth];
        ref_counts[r.result_id] = 1;
        r.ref_count            = 1;
      end
    end else if ({1'b0, id} >= pool_size) begin
      r.status = ST_BAD_ID;
    end else if (req.op == OP_QUERY) begin
      r.ref_count = ref_counts[id];
    end else if (ref_counts[id] == 0) begin
      r.status = ST_FREE;
    end else if (req.op == OP_INC) begin
      if (ref_counts[id] == CountMax) begin
        r.status = ST_OVERFLOW;
      end else begin
        ref_counts[id] = ref_counts[id] + 1'b1;
      end
      r.ref_count = ref_counts[id];
    end else begin
      ref_counts[id] = ref_counts[id] - 1'b1;
      r.ref_count    = ref_counts[id];
      // last reference gone: id goes back on top of the free stack
      if (ref_counts[id] == 0 && free_depth < DepthW'(MaxBlocks)) begin
        free_ids[free_depth] = id;
        free_depth           = free_depth + 1'b1;
      end
    end
    r.free_count = free_depth;
    return r;
  endfunction

  // idle cycles before the next word, with occasional stretches of none
  function automatic int unsigned idle_draw(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 40);
    if (!idle_on) return 0;
    return $urandom_range(0, 14);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && in_ready_o) rsp_due = {rsp_due, predict_rsp(in_req_i)};
      if (!in_valid_i || in_ready_o) begin
        if (in_gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap     <= in_gap - 1;
        end else if (req_backlog.size() != 0) begin
          in_req_i   <= req_backlog.pop_front();
          in_valid_i <= 1'b1;
          in_gap     <= idle_draw(in_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned hold_next;
    rsp_t        want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_hold    <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (rsp_due.size() == 0) begin
          $error("response word with no request outstanding");
          mismatches++;
        end else begin
          want = rsp_due.pop_front();
          if (out_rsp_o.result_id !== want.result_id) begin
            $error("result_id: expected %0d, actual %0d", want.result_id, out_rsp_o.result_id);
            mismatches++;
          end
          if (out_rsp_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_rsp_o.status);
            mismatches++;
          end
          if (out_rsp_o.ref_count !== want.ref_count) begin
            $error("ref_count: expected %0d, actual %0d", want.ref_count, out_rsp_o.ref_count);
            mismatches++;
          end
          if (out_rsp_o.free_count !== want.free_count) begin
            $error("free_count: expected %0d, actual %0d", want.free_count,
                   out_rsp_o.free_count);
            mismatches++;
          end
        end
        hold_next = idle_draw(out_calm);
      end else begin
        hold_next = (out_hold != 0) ? out_hold - 1 : 0;
      end
      out_hold    <= hold_next;
      out_ready_i <= (hold_next == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_req(input op_e op, input int unsigned id);
    req_t r;
    r.op        = op;
    r.block_id  = IdW'(id);
    req_backlog = {req_backlog, r};
  endtask

  task automatic drain();
    while (req_backlog.size() != 0 || in_valid_i || rsp_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic resize_pool(input logic [DepthW-1:0] blocks);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= blocks;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pool_setup(blocks);
  endtask

  task automatic random_items(input int unsigned n);
    int unsigned pick;
    int unsigned span;
    int unsigned id;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      // mostly ids near the top of the pool, where allocations land first
      if (pool_size == 0 || $urandom_range(0, 7) == 0) begin
        id = $urandom_range(0, MaxBlocks - 1);
      end else begin
        span = (pool_size > 24) ? 24 : pool_size;
        id   = pool_size - 1 - $urandom_range(0, span - 1);
      end
      if (pick < 30)      add_req(OP_ALLOC, id);
      else if (pick < 55) add_req(OP_INC, id);
      else if (pick < 85) add_req(OP_DEC, id);
      else                add_req(OP_QUERY, id);
    end
  endtask

  initial begin
    #1;
    rst_ni = 1'b0;
    pool_setup(ActiveReset);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full pool from reset
    add_req(OP_QUERY, 0);
    add_req(OP_INC, 5);
    add_req(OP_DEC, 5);
    add_req(OP_QUERY, 1023);
    add_req(OP_ALLOC, 0);
    add_req(OP_ALLOC, 1023);
    add_req(OP_INC, 1023);
    add_req(OP_QUERY, 1023);
    add_req(OP_DEC, 1023);
    add_req(OP_DEC, 1023);
    add_req(OP_DEC, 1023);
    add_req(OP_ALLOC, 512);
    add_req(OP_DEC, 1022);

    // empty pool: nothing to hand out, every id out of range
    resize_pool('0);
    add_req(OP_ALLOC, 0);
    add_req(OP_QUERY, 0);
    add_req(OP_INC, 1023);
    add_req(OP_DEC, 512);

    // oversized write saturates to the full pool
    resize_pool('1);
    add_req(OP_QUERY, 1023);
    add_req(OP_ALLOC, 0);
    random_items(200);

    // single block pool, back to back
    resize_pool(1);
    drain();
    idle_on = 1'b0;
    add_req(OP_ALLOC, 0);
    add_req(OP_ALLOC, 0);
    add_req(OP_QUERY, 1);
    repeat (20) add_req(OP_INC, 0);
    add_req(OP_QUERY, 0);
    repeat (21) add_req(OP_DEC, 0);
    add_req(OP_INC, 0);
    add_req(OP_ALLOC, 0);
    drain();
    idle_on = 1'b1;

    resize_pool(8);
    random_items(200);
    resize_pool(DepthW'($urandom_range(1, MaxBlocks)));
    random_items(150);
    resize_pool(DepthW'(MaxBlocks));
    random_items(100);

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/rba_pkg.sv
hdl/rba_init_seq.sv
hdl/rba_free_stack.sv
hdl/rba_count_table.sv
hdl/refcounted_block_allocator_unit.sv
test/tb_refcounted_block_allocator_unit.sv
